### rtl/dmv_pkg.sv
package dmv_pkg;

    // Command codes carried in the action field.
    localparam logic [3:0] ACT_WELEM    = 4'd0;
    localparam logic [3:0] ACT_WVEC     = 4'd1;
    localparam logic [3:0] ACT_RELEM    = 4'd2;
    localparam logic [3:0] ACT_AX       = 4'd3;
    localparam logic [3:0] ACT_ATX      = 4'd4;
    localparam logic [3:0] ACT_ROWSUM   = 4'd5;
    localparam logic [3:0] ACT_ROWSUMSQ = 4'd6;
    localparam logic [3:0] ACT_COLSUM   = 4'd7;
    localparam logic [3:0] ACT_COLSUMSQ = 4'd8;
    localparam logic [3:0] ACT_ROWSCALE = 4'd9;
    localparam logic [3:0] ACT_COLSCALE = 4'd10;
    localparam logic [3:0] ACT_CLEAR    = 4'd11;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Fixed field widths.
    localparam int IDX_W = 5;
    localparam int VAL_W = 16;
    localparam int RES_W = 40;
    localparam int CNT_W = 7;

    // Class of a command after decode.
    typedef enum logic [2:0] {
        K_WELEM, K_WVEC, K_RELEM, K_ROW, K_COL, K_SCALE, K_CLEAR, K_ERR
    } t_kind;

    // Second factor of each product in a reduction.
    typedef enum logic [1:0] {
        SRC_VEC, SRC_ONE, SRC_SELF
    } t_src;

    typedef struct packed {
        t_kind                    kind;
        t_src                     src;
        logic                     by_row;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         vi;
        logic [IDX_W-1:0]         res_idx;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic signed [RES_W-1:0]  value;
        logic [IDX_W-1:0]         index;
        logic                     last;
        logic                     error;
    } t_res;

endpackage

### rtl/dmv_ram.sv
module dmv_ram
    import dmv_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dmv_front.sv
module dmv_front
    import dmv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [3:0]       i_action,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_col,
    input  logic [IDX_W-1:0] i_vi,
    input  logic [VAL_W-1:0] i_value,
    input  logic [CNT_W-1:0] i_nr,
    input  logic [CNT_W-1:0] i_nc,
    input  logic             i_hold,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output t_cmd             o_cmd
);

    t_cmd             w_cmd;
    logic [CNT_W-1:0] w_nmax;
    t_cmd             r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign w_nmax = (i_nr > i_nc) ? i_nr : i_nc;

    // Decode the action and check indexes against the sizes in use.
    always_comb begin
        w_cmd         = '0;
        w_cmd.row     = i_row;
        w_cmd.col     = i_col;
        w_cmd.vi      = i_vi;
        w_cmd.value   = i_value;
        w_cmd.res_idx = '0;
        w_cmd.src     = SRC_ONE;
        w_cmd.by_row  = 1'b0;
        w_cmd.kind    = K_ERR;
        unique case (i_action) inside
            ACT_WELEM, ACT_RELEM: begin
                w_cmd.res_idx = i_row;
                if (CNT_W'(i_row) >= i_nr || CNT_W'(i_col) >= i_nc) begin
                    w_cmd.kind = K_ERR;
                end else begin
                    w_cmd.kind = (i_action == ACT_WELEM) ? K_WELEM : K_RELEM;
                end
            end
            ACT_WVEC: begin
                w_cmd.res_idx = i_vi;
                w_cmd.kind    = (CNT_W'(i_vi) >= w_nmax) ? K_ERR : K_WVEC;
            end
            ACT_AX, ACT_ROWSUM, ACT_ROWSUMSQ: begin
                w_cmd.kind = K_ROW;
                w_cmd.src  = (i_action == ACT_AX) ? SRC_VEC :
                             (i_action == ACT_ROWSUM) ? SRC_ONE : SRC_SELF;
            end
            ACT_ATX, ACT_COLSUM, ACT_COLSUMSQ: begin
                w_cmd.kind = K_COL;
                w_cmd.src  = (i_action == ACT_ATX) ? SRC_VEC :
                             (i_action == ACT_COLSUM) ? SRC_ONE : SRC_SELF;
            end
            ACT_ROWSCALE, ACT_COLSCALE: begin
                w_cmd.kind   = K_SCALE;
                w_cmd.by_row = (i_action == ACT_ROWSCALE);
            end
            ACT_CLEAR: begin
                w_cmd.kind = K_CLEAR;
            end
            default: begin
                w_cmd.kind = K_ERR;
            end
        endcase
    end

    // Two-entry command queue toward the execution unit.
    assign o_in_ready  = (r_cnt != 2'd2) && !i_hold;
    assign w_push      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### rtl/dmv_back.sv
module dmv_back
    import dmv_pkg::*;
#(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    input  logic [CNT_W-1:0] i_nr,
    input  logic [CNT_W-1:0] i_nc,
    output logic             o_init_busy,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_res             o_res
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VDEP  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int VIW   = (VDEP > 1) ? $clog2(VDEP) : 1;
    localparam int EW    = ELEM_WIDTH;
    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int SW    = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
    localparam int OW    = (ACC_WIDTH > RES_W) ? ACC_WIDTH : RES_W;

    localparam logic signed [PW-1:0] EMAX_P = {{(PW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [PW-1:0] EMIN_P = ~EMAX_P;
    localparam logic signed [31:0]   EMAX_V = {{(33-EW){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [31:0]   EMIN_V = ~EMAX_V;
    localparam logic signed [SW-1:0] AMAX_S =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN_S = ~AMAX_S;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_EMIT  = 9'b000100000,
        S_SWR   = 9'b001000000,
        S_RESP  = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    t_cmd                      r_cmd;
    logic                      r_init;
    logic [AW-1:0]             r_ca;
    logic [CNT_W-1:0]          r_i;
    logic [CNT_W-1:0]          r_j;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [PW-1:0]      r_prod;
    logic signed [EW-1:0]      r_e;
    logic signed [EW-1:0]      r_vec [VDEP];
    logic                      r_ov;
    t_res                      r_res;

    logic                      w_free;
    logic [CNT_W-1:0]          w_outer_n;
    logic [CNT_W-1:0]          w_inner_n;
    logic                      w_inner_last;
    logic                      w_outer_last;
    logic [CNT_W-1:0]          w_r;
    logic [CNT_W-1:0]          w_c;
    logic [AW-1:0]             w_addr;
    logic [EW-1:0]             w_rdata;
    logic signed [EW-1:0]      w_e;
    logic signed [EW-1:0]      w_f;
    logic [VIW-1:0]            w_fidx;
    logic signed [SW-1:0]      w_sum;
    logic signed [ACC_WIDTH-1:0] w_acc_sat;
    logic signed [EW-1:0]      w_prod_sat;
    logic signed [31:0]        w_v32;
    logic signed [EW-1:0]      w_val_sat;
    logic signed [OW-1:0]      w_acc_ext;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [EW-1:0]             w_wdata;

    assign w_free      = !r_ov || i_res_ready;
    assign o_init_busy = r_init;
    assign o_cmd_ready = (r_state == S_IDLE);

    // Loop bounds: columns outer for column results, rows outer otherwise (row results and scaling).
    assign w_outer_n    = (r_cmd.kind == K_COL) ? i_nc : i_nr;
    assign w_inner_n    = (r_cmd.kind == K_COL) ? i_nr : i_nc;
    assign w_inner_last = (r_j == w_inner_n - CNT_W'(1));
    assign w_outer_last = (r_i == w_outer_n - CNT_W'(1));

    // Matrix coordinates of the current element.
    always_comb begin
        if (r_cmd.kind == K_RELEM) begin
            w_r = CNT_W'(r_cmd.row);
            w_c = CNT_W'(r_cmd.col);
        end else if (r_cmd.kind == K_COL) begin
            w_r = r_j;
            w_c = r_i;
        end else begin
            w_r = r_i;
            w_c = r_j;
        end
    end

    assign w_addr = AW'(32'(w_r) * 32'(MAX_COLS) + 32'(w_c));

    // Second factor of the product.
    assign w_e = signed'(w_rdata);
    always_comb begin
        if (r_cmd.kind == K_SCALE) begin
            w_fidx = r_cmd.by_row ? VIW'(r_i) : VIW'(r_j);
        end else begin
            w_fidx = VIW'(r_j);
        end
        case (r_cmd.src)
            SRC_VEC:  w_f = r_vec[w_fidx];
            SRC_SELF: w_f = w_e;
            default:  w_f = EW'(1);
        endcase
        if (r_cmd.kind == K_SCALE) begin
            w_f = r_vec[w_fidx];
        end
    end

    // Saturating accumulate and element saturation.
    assign w_sum     = SW'(r_acc) + SW'(r_prod);
    assign w_acc_sat = (w_sum > AMAX_S) ? ACC_WIDTH'(AMAX_S) :
                       (w_sum < AMIN_S) ? ACC_WIDTH'(AMIN_S) : ACC_WIDTH'(w_sum);
    assign w_prod_sat = (r_prod > EMAX_P) ? EW'(EMAX_P) :
                        (r_prod < EMIN_P) ? EW'(EMIN_P) : EW'(r_prod);
    assign w_v32      = 32'(r_cmd.value);
    assign w_val_sat  = (w_v32 > EMAX_V) ? EW'(EMAX_V) :
                        (w_v32 < EMIN_V) ? EW'(EMIN_V) : EW'(w_v32);
    assign w_acc_ext  = OW'(r_acc);

    // Matrix store write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = w_prod_sat;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_ca;
            w_wdata = '0;
        end else if (r_state == S_SWR) begin
            w_we = 1'b1;
        end else if (r_state == S_RESP && w_free && r_cmd.kind == K_WELEM) begin
            w_we    = 1'b1;
            w_waddr = AW'(32'(r_cmd.row) * 32'(MAX_COLS) + 32'(r_cmd.col));
            w_wdata = w_val_sat;
        end
    end

    dmv_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_mat (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_ca == AW'(DEPTH - 1)) begin
                    n_state = r_init ? S_IDLE : S_RESP;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind) inside
                        K_ROW, K_COL, K_SCALE, K_RELEM: n_state = S_RD;
                        K_CLEAR:                        n_state = S_CLEAR;
                        default:                        n_state = S_RESP;
                    endcase
                end
            end
            S_RD:   n_state = S_MUL;
            S_MUL: begin
                unique case (r_cmd.kind) inside
                    K_RELEM: n_state = S_RESP;
                    K_SCALE: n_state = S_SWR;
                    default: n_state = S_ACC;
                endcase
            end
            S_ACC:  n_state = w_inner_last ? S_EMIT : S_RD;
            S_EMIT: begin
                if (w_free) begin
                    n_state = w_outer_last ? S_IDLE : S_RD;
                end
            end
            S_SWR: begin
                n_state = (w_inner_last && w_outer_last) ? S_RESP : S_RD;
            end
            S_RESP: begin
                if (w_free) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_init  <= 1'b1;
            r_ca    <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_ca <= r_ca + AW'(1);
                    if (r_ca == AW'(DEPTH - 1)) begin
                        r_init <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_ca <= '0;
                    r_i  <= '0;
                    r_j  <= '0;
                end
                S_ACC, S_SWR: begin
                    if (!w_inner_last) begin
                        r_j <= r_j + CNT_W'(1);
                    end else if (r_state == S_SWR) begin
                        r_j <= '0;
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_j <= '0;
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_IDLE || (r_state == S_EMIT && w_free)) begin
            r_acc <= '0;
        end else if (r_state == S_ACC) begin
            r_acc <= w_acc_sat;
        end
        if (r_state == S_MUL) begin
            r_e    <= w_e;
            r_prod <= PW'(w_e) * PW'(w_f);
        end
    end

    // Vector store, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VDEP; k++) begin
                r_vec[k] <= '0;
            end
        end else if (r_state == S_RESP && w_free && r_cmd.kind == K_WVEC) begin
            r_vec[VIW'(r_cmd.vi)] <= w_val_sat;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_EMIT && w_free) begin
            r_ov        <= 1'b1;
            r_res.value <= w_acc_ext[RES_W-1:0];
            r_res.index <= IDX_W'(r_i);
            r_res.last  <= w_outer_last;
            r_res.error <= 1'b0;
        end else if (r_state == S_RESP && w_free) begin
            r_ov        <= 1'b1;
            r_res.value <= (r_cmd.kind == K_RELEM) ? RES_W'(r_e) : '0;
            r_res.index <= r_cmd.res_idx;
            r_res.last  <= 1'b1;
            r_res.error <= (r_cmd.kind == K_ERR);
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_loop_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_SWR) |-> (r_j < w_inner_n && r_i < w_outer_n))
        else $error("loop counter beyond size in use");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_free && w_outer_last) |=> (r_state == S_IDLE && r_res.last))
        else $error("final stream result did not end the command");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_res_ready) |=> (r_ov && $stable(r_res)))
        else $error("pending result overwritten");

    a_no_cmd_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == S_CLEAR))
        else $error("command started during reset clearing");
`endif

endmodule

### rtl/dense_matrix_vector_engine.sv
// Dense matrix-vector engine. Commands arrive on the slave stream and sit in a
// two-entry queue; a sequencer executes them one at a time against a matrix RAM
// with one write port and one registered read port, and a register-file vector.
// Element and vector writes and errors each end with one response; an element read
// returns the stored element; A*x, A^T*x and the sum commands emit one result
// per row or column; row or column scaling rewrites every element in use and
// then responds; clear walks the whole RAM. After reset the block zeroes the
// matrix RAM and accepts no command until that pass is done.
// Results leave through an output register, so a stalled master side only stops
// the sequencer when a new result is ready to load.
module dense_matrix_vector_engine
    import dmv_pkg::*;
#(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[3:0], row[8:4], col[13:9], vec_index[18:14], value[34:19], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value[39:0], result_index[44:40], zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // error[0]
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    logic [5:0]       r_rows;
    logic [5:0]       r_cols;
    logic [CNT_W-1:0] w_nr;
    logic [CNT_W-1:0] w_nc;
    logic             w_cmd_valid;
    logic             w_cmd_ready;
    t_cmd             w_cmd;
    logic             w_init_busy;
    t_res             w_res;

    // Size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 6'd32;
            r_cols <= 6'd32;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end else begin
                r_cols <= i_cfg_data;
            end
        end
    end

    // Sizes in use: zero counts as one, large values are held to the maximum.
    assign w_nr = (r_rows == 6'd0) ? CNT_W'(1) :
                  (CNT_W'(r_rows) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(r_rows);
    assign w_nc = (r_cols == 6'd0) ? CNT_W'(1) :
                  (CNT_W'(r_cols) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(r_cols);

    dmv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tdata[3:0]),
        .i_row       (s_axis_tdata[8:4]),
        .i_col       (s_axis_tdata[13:9]),
        .i_vi        (s_axis_tdata[18:14]),
        .i_value     (s_axis_tdata[34:19]),
        .i_nr        (w_nr),
        .i_nc        (w_nc),
        .i_hold      (w_init_busy),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    dmv_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_nr        (w_nr),
        .i_nc        (w_nc),
        .o_init_busy (w_init_busy),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.index, w_res.value};
    assign m_axis_tlast = w_res.last;
    assign m_axis_tuser = w_res.error;

endmodule
